### design/aevad_pkg.sv
// ----------------------------------------------------------------------------
// aevad_pkg
// shared types and constants of the adaptive energy vad with auto stop
// ----------------------------------------------------------------------------
package aevad_pkg;

  // q2.16 coefficient format, widest coefficient is 2.4 which needs 18 bits
  localparam int unsigned COEF_BITS      = 18;
  localparam int unsigned COEF_FRAC_BITS = 16;

  localparam logic [COEF_BITS-1:0] K_SLOW_KEEP = 18'd64225;  // 0.98
  localparam logic [COEF_BITS-1:0] K_SLOW_NEW  = 18'd1311;   // 0.02
  localparam logic [COEF_BITS-1:0] K_FAST_KEEP = 18'd58982;  // 0.9
  localparam logic [COEF_BITS-1:0] K_FAST_NEW  = 18'd6554;   // 0.1
  localparam logic [COEF_BITS-1:0] K_SPEECH    = 18'd157286; // 2.4
  localparam logic [COEF_BITS-1:0] K_SILENCE   = 18'd98304;  // 1.5

  // configuration port
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned FRAME_BITS    = 8;
  localparam int unsigned MIN_BITS      = 16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MIN_SPEECH_FRAMES = 3'd0,
    CFG_SILENCE_LIMIT     = 3'd1,
    CFG_FLOOR_MIN         = 3'd2,
    CFG_SPEECH_THR_MIN    = 3'd3,
    CFG_SILENCE_THR_MIN   = 3'd4
  } cfg_idx_e;

  localparam logic [FRAME_BITS-1:0] MIN_SPEECH_FRAMES_RST = 8'd4;
  localparam logic [FRAME_BITS-1:0] SILENCE_LIMIT_RST     = 8'd50;
  localparam logic [MIN_BITS-1:0]   FLOOR_MIN_RST         = 16'd98;
  localparam logic [MIN_BITS-1:0]   SPEECH_THR_MIN_RST    = 16'd426;
  localparam logic [MIN_BITS-1:0]   SILENCE_THR_MIN_RST   = 16'd295;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_POLL  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    CAUSE_NONE    = 2'd0,
    CAUSE_KEY     = 2'd1,
    CAUSE_SILENCE = 2'd2
  } stop_cause_e;

  // control of the serial multiply-accumulate units
  typedef struct packed {
    logic clear;
    logic step;
  } smac_ctrl_t;

endpackage

### design/aevad_if.sv
// ----------------------------------------------------------------------------
// aevad channel interfaces
// valid/ready channels for level words, result words and register writes
// ----------------------------------------------------------------------------
interface aevad_in_if #(
  parameter int unsigned LEVEL_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic                  key_released;
  logic [LEVEL_BITS-1:0] level;

  modport source (output valid, cmd, key_released, level, input ready);
  modport sink   (input valid, cmd, key_released, level, output ready);
endinterface

interface aevad_out_if #(
  parameter int unsigned LEVEL_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic                  stop_request;
  logic [1:0]            stop_cause;
  logic                  is_speech;
  logic [LEVEL_BITS-1:0] floor_level;

  modport source (output valid, stop_request, stop_cause, is_speech, floor_level, input ready);
  modport sink   (input valid, stop_request, stop_cause, is_speech, floor_level, output ready);
endinterface

interface aevad_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/aevad_smac.sv
// ----------------------------------------------------------------------------
// aevad_smac
// bit-serial multiply-accumulate: a*coef_a + b*coef_b; while step is held, one operand bit a cycle
// ----------------------------------------------------------------------------
module aevad_smac import aevad_pkg::*; #(
  parameter int unsigned OP_BITS = 16
) (
  input  logic                          clk_i,
  input  smac_ctrl_t                    ctrl_i,
  input  logic                          bit_a_i,
  input  logic                          bit_b_i,
  input  logic [COEF_BITS-1:0]          coef_a_i,
  input  logic [COEF_BITS-1:0]          coef_b_i,
  output logic [OP_BITS+COEF_BITS-1:0]  prod_o
);

  localparam int unsigned ACC_BITS = OP_BITS + COEF_BITS;

  logic [ACC_BITS-1:0]  acc_q, acc_d;
  logic [COEF_BITS:0]   addend;
  logic [COEF_BITS:0]   upper_sum;
  logic [ACC_BITS:0]    shifted;

  // partial products enter at the top, the accumulator shifts right
  assign addend    = (bit_a_i ? {1'b0, coef_a_i} : '0) + (bit_b_i ? {1'b0, coef_b_i} : '0);
  assign upper_sum = {1'b0, acc_q[ACC_BITS-1:OP_BITS]} + addend;
  assign shifted   = {upper_sum, acc_q[OP_BITS-1:0]};

  always_comb begin
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.step) begin
      acc_d = shifted[ACC_BITS:1];
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign prod_o = acc_q;

endmodule

### design/adaptive_energy_vad_autostop.sv
// ----------------------------------------------------------------------------
// adaptive_energy_vad_autostop
// energy voice-activity detector with adaptive noise floor and auto stop
// ----------------------------------------------------------------------------
//  channel   dir  handshake     word contents
//  in_ch     in   valid/ready   cmd, key_released, level
//  out_ch    out  valid/ready   stop_request, stop_cause, is_speech, floor_level
//  cfg_ch    in   valid/ready   index, data (register write, always ready)
//
//  an evaluated poll (recording, key held) makes two bit-serial passes through
//  the shared multiply-accumulate units, S_BLEND then S_THRESH with S_FLOOR1
//  between them, before S_DONE; starts, idle polls and key releases go to S_DONE
//  one word is in flight at a time; a finished result sits in the output
//  register while the next word is accepted and computed
//  reset clears the control state, the floor to 0.004 and the configuration
//  registers to their defaults; no clearing pass is needed
// ----------------------------------------------------------------------------
module adaptive_energy_vad_autostop import aevad_pkg::*; #(
  parameter int unsigned LEVEL_BITS = 16,
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  aevad_in_if.sink    in_ch,
  aevad_out_if.source out_ch,
  aevad_cfg_if.sink   cfg_ch
);

  localparam int unsigned ACC_BITS  = LEVEL_BITS + COEF_BITS;
  localparam int unsigned STEP_BITS = $clog2(LEVEL_BITS);
  localparam int unsigned MW        = (LEVEL_BITS > MIN_BITS) ? LEVEL_BITS : MIN_BITS;
  localparam int unsigned TW        = (LEVEL_BITS + 2 > MIN_BITS) ? LEVEL_BITS + 2 : MIN_BITS;
  localparam int unsigned CW        = (COUNT_BITS > FRAME_BITS) ? COUNT_BITS : FRAME_BITS;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [STEP_BITS-1:0]  STEP_LAST = STEP_BITS'(LEVEL_BITS - 1);
  // 0.004 of full scale, truncated
  localparam longint unsigned FLOOR_RESET_INT = ((64'd1 << LEVEL_BITS) * 4) / 1000;
  localparam logic [LEVEL_BITS-1:0] FLOOR_RESET = LEVEL_BITS'(FLOOR_RESET_INT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BLEND,
    S_FLOOR1,
    S_THRESH,
    S_DONE
  } state_e;

  // configuration registers
  logic [FRAME_BITS-1:0] min_speech_q, silence_limit_q;
  logic [MIN_BITS-1:0]   floor_min_q, speech_min_q, silence_min_q;

  // control state
  state_e                state_q;
  logic [STEP_BITS-1:0]  step_q;
  logic                  active_q;
  logic [LEVEL_BITS-1:0] floor_q;
  logic [COUNT_BITS-1:0] speech_cnt_q, silence_cnt_q;
  logic                  out_valid_q;

  // word payload and serial operands
  cmd_e                  cmd_q;
  logic                  key_q;
  logic [LEVEL_BITS-1:0] level_q;
  logic [LEVEL_BITS-1:0] fl_sr_q, lv_sr_q;
  logic [LEVEL_BITS-1:0] floor1_q;
  logic                  out_stop_q, out_speech_q;
  stop_cause_e           out_cause_q;
  logic [LEVEL_BITS-1:0] out_floor_q;

  logic                  in_accept, out_free, commit, eval_in, eval_w;
  smac_ctrl_t            smac_ctrl;
  logic [COEF_BITS-1:0]  blend_keep, blend_new;
  logic [ACC_BITS-1:0]   blend_prod, speech_prod, silence_prod;

  // ---------------------------------------------------------------------------
  // configuration writes, index outside the list is dropped
  // ---------------------------------------------------------------------------
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_speech_q    <= MIN_SPEECH_FRAMES_RST;
      silence_limit_q <= SILENCE_LIMIT_RST;
      floor_min_q     <= FLOOR_MIN_RST;
      speech_min_q    <= SPEECH_THR_MIN_RST;
      silence_min_q   <= SILENCE_THR_MIN_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_e'(cfg_ch.index))
        CFG_MIN_SPEECH_FRAMES: min_speech_q    <= cfg_ch.data[FRAME_BITS-1:0];
        CFG_SILENCE_LIMIT:     silence_limit_q <= cfg_ch.data[FRAME_BITS-1:0];
        CFG_FLOOR_MIN:         floor_min_q     <= cfg_ch.data[MIN_BITS-1:0];
        CFG_SPEECH_THR_MIN:    speech_min_q    <= cfg_ch.data[MIN_BITS-1:0];
        CFG_SILENCE_THR_MIN:   silence_min_q   <= cfg_ch.data[MIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------------
  assign in_ch.ready = (state_q == S_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_q || out_ch.ready;
  assign commit      = (state_q == S_DONE) && out_free;

  // level is only evaluated on a poll while recording with the key still held
  assign eval_in = (cmd_e'(in_ch.cmd) == CMD_POLL) && active_q && !in_ch.key_released;
  assign eval_w  = (cmd_q == CMD_POLL) && active_q && !key_q;

  // ---------------------------------------------------------------------------
  // serial multiply units
  // pass 1: slow blend of floor and level
  // pass 2: fast blend plus both thresholds, all from the pass-1 floor
  // ---------------------------------------------------------------------------
  assign smac_ctrl.clear = in_accept || (state_q == S_FLOOR1);
  assign smac_ctrl.step  = (state_q == S_BLEND) || (state_q == S_THRESH);
  assign blend_keep      = (state_q == S_THRESH) ? K_FAST_KEEP : K_SLOW_KEEP;
  assign blend_new       = (state_q == S_THRESH) ? K_FAST_NEW  : K_SLOW_NEW;

  aevad_smac #(.OP_BITS(LEVEL_BITS)) u_blend (
    .clk_i    (clk_i),
    .ctrl_i   (smac_ctrl),
    .bit_a_i  (fl_sr_q[0]),
    .bit_b_i  (lv_sr_q[0]),
    .coef_a_i (blend_keep),
    .coef_b_i (blend_new),
    .prod_o   (blend_prod)
  );

  aevad_smac #(.OP_BITS(LEVEL_BITS)) u_speech_thr (
    .clk_i    (clk_i),
    .ctrl_i   (smac_ctrl),
    .bit_a_i  (fl_sr_q[0]),
    .bit_b_i  (1'b0),
    .coef_a_i (K_SPEECH),
    .coef_b_i ('0),
    .prod_o   (speech_prod)
  );

  aevad_smac #(.OP_BITS(LEVEL_BITS)) u_silence_thr (
    .clk_i    (clk_i),
    .ctrl_i   (smac_ctrl),
    .bit_a_i  (fl_sr_q[0]),
    .bit_b_i  (1'b0),
    .coef_a_i (K_SILENCE),
    .coef_b_i ('0),
    .prod_o   (silence_prod)
  );

  // ---------------------------------------------------------------------------
  // floor clamp, thresholds and the tick decision
  // ---------------------------------------------------------------------------
  logic [MW-1:0]         lim_wide;
  logic [LEVEL_BITS-1:0] floor_lim, blend_val, blend_clamped;
  logic [TW-1:0]         speech_thr, silence_thr, level_w, sp_raw, si_raw;
  logic                  speech_hit, silent_hit, fast_adapt, sil_stop;
  logic [COUNT_BITS-1:0] sc_upd, slc_upd;

  logic                  res_stop, res_speech, nxt_active;
  stop_cause_e           res_cause;
  logic [LEVEL_BITS-1:0] nxt_floor;
  logic [COUNT_BITS-1:0] nxt_sc, nxt_slc;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == COUNT_MAX) ? COUNT_MAX : c + 1'b1;
  endfunction

  // floor minimum limited to the level range
  assign lim_wide  = (MW'(floor_min_q) > MW'(LEVEL_MAX)) ? MW'(LEVEL_MAX) : MW'(floor_min_q);
  assign floor_lim = lim_wide[LEVEL_BITS-1:0];

  // blend result is q2.16 product >> 16, then clamped below
  assign blend_val     = blend_prod[LEVEL_BITS+COEF_FRAC_BITS-1:COEF_FRAC_BITS];
  assign blend_clamped = (blend_val < floor_lim) ? floor_lim : blend_val;

  // thresholds are kept wider than a level so they never clip
  assign sp_raw      = TW'(speech_prod[LEVEL_BITS+COEF_FRAC_BITS+1:COEF_FRAC_BITS]);
  assign si_raw      = TW'(silence_prod[LEVEL_BITS+COEF_FRAC_BITS:COEF_FRAC_BITS]);
  assign speech_thr  = (sp_raw < TW'(speech_min_q))  ? TW'(speech_min_q)  : sp_raw;
  assign silence_thr = (si_raw < TW'(silence_min_q)) ? TW'(silence_min_q) : si_raw;
  assign level_w     = TW'(level_q);

  assign speech_hit = (level_w >= speech_thr);
  assign silent_hit = !speech_hit && (CW'(speech_cnt_q) >= CW'(min_speech_q))
                      && (level_w <= silence_thr);
  // fast adaptation only before any speech has been seen
  assign fast_adapt = !speech_hit && !silent_hit && (speech_cnt_q == '0);

  assign sc_upd   = speech_hit ? sat_inc(speech_cnt_q) : speech_cnt_q;
  assign slc_upd  = speech_hit ? '0 : (silent_hit ? sat_inc(silence_cnt_q) : silence_cnt_q);
  assign sil_stop = (CW'(sc_upd) >= CW'(min_speech_q))
                    && (CW'(slc_upd) > CW'(silence_limit_q));

  always_comb begin
    res_stop   = 1'b0;
    res_cause  = CAUSE_NONE;
    res_speech = 1'b0;
    nxt_active = active_q;
    nxt_floor  = floor_q;
    nxt_sc     = speech_cnt_q;
    nxt_slc    = silence_cnt_q;
    if (eval_w) begin
      res_speech = speech_hit;
      nxt_floor  = fast_adapt ? blend_clamped : floor1_q;
      nxt_sc     = sc_upd;
      nxt_slc    = slc_upd;
      if (sil_stop) begin
        nxt_sc     = '0;
        nxt_slc    = '0;
        nxt_active = 1'b0;
        res_stop   = 1'b1;
        res_cause  = CAUSE_SILENCE;
      end
    end else if (cmd_q == CMD_START) begin
      // start while recording is ignored
      if (!active_q) begin
        nxt_active = 1'b1;
        nxt_sc     = '0;
        nxt_slc    = '0;
      end
    end else if (active_q) begin
      // poll with the key released
      nxt_active = 1'b0;
      res_stop   = 1'b1;
      res_cause  = CAUSE_KEY;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer and state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      step_q        <= '0;
      active_q      <= 1'b0;
      floor_q       <= FLOOR_RESET;
      speech_cnt_q  <= '0;
      silence_cnt_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      // a new word replaces the old one, otherwise an accepted word leaves
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            step_q  <= '0;
            state_q <= eval_in ? S_BLEND : S_DONE;
          end
        end
        S_BLEND: begin
          step_q <= step_q + 1'b1;
          if (step_q == STEP_LAST) begin
            state_q <= S_FLOOR1;
          end
        end
        S_FLOOR1: begin
          step_q  <= '0;
          state_q <= S_THRESH;
        end
        S_THRESH: begin
          step_q <= step_q + 1'b1;
          if (step_q == STEP_LAST) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            active_q      <= nxt_active;
            floor_q       <= nxt_floor;
            speech_cnt_q  <= nxt_sc;
            silence_cnt_q <= nxt_slc;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload, operand shift registers and the result word
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q   <= cmd_e'(in_ch.cmd);
      key_q   <= in_ch.key_released;
      level_q <= in_ch.level;
      fl_sr_q <= floor_q;
      lv_sr_q <= in_ch.level;
    end else if (state_q == S_FLOOR1) begin
      floor1_q <= blend_clamped;
      fl_sr_q  <= blend_clamped;
      lv_sr_q  <= level_q;
    end else if (smac_ctrl.step) begin
      fl_sr_q <= fl_sr_q >> 1;
      lv_sr_q <= lv_sr_q >> 1;
    end
    if (commit) begin
      out_stop_q   <= res_stop;
      out_cause_q  <= res_cause;
      out_speech_q <= res_speech;
      out_floor_q  <= nxt_floor;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.stop_request = out_stop_q;
  assign out_ch.stop_cause   = out_cause_q;
  assign out_ch.is_speech    = out_speech_q;
  assign out_ch.floor_level  = out_floor_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // the recording only ends together with a stop word
  a_stop_on_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(active_q) |-> (out_valid_q && out_stop_q))
    else $error("recording ended without a stop word");

  // a silence stop can never be a speech tick
  a_silence_not_speech: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_cause_q == CAUSE_SILENCE)) |-> !out_speech_q)
    else $error("silence stop flagged as speech");

  // a key release skips level evaluation
  a_key_no_speech: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_speech_q) |-> (out_cause_q != CAUSE_KEY))
    else $error("key release word flagged as speech");

  // stop flag and cause agree
  a_stop_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_stop_q == (out_cause_q != CAUSE_NONE)))
    else $error("stop flag and cause disagree");

endmodule
